// File: rtl/core/ehpd_pkg.sv
// Package for the exception-frame encoded pointer decoder.
// Holds the word types, encoding codes, status codes and form helpers.
// No dependencies.
package ehpd_pkg;

    // Base selector codes (high nibble of the encoding byte)
    localparam logic [3:0] BASE_ABS      = 4'h0;
    localparam logic [3:0] BASE_PCREL    = 4'h1;
    localparam logic [3:0] BASE_TEXTREL  = 4'h2;
    localparam logic [3:0] BASE_DATAREL  = 4'h3;
    localparam logic [3:0] BASE_INDIRECT = 4'h8;
    localparam logic [3:0] BASE_IND_PC   = 4'h9;

    // Value form codes (low nibble of the encoding byte)
    localparam logic [3:0] FORM_ABSPTR  = 4'h0;
    localparam logic [3:0] FORM_ULEB128 = 4'h1;
    localparam logic [3:0] FORM_UDATA2  = 4'h2;
    localparam logic [3:0] FORM_UDATA4  = 4'h3;
    localparam logic [3:0] FORM_UDATA8  = 4'h4;
    localparam logic [3:0] FORM_SLEB128 = 4'h9;
    localparam logic [3:0] FORM_SDATA2  = 4'ha;
    localparam logic [3:0] FORM_SDATA4  = 4'hb;
    localparam logic [3:0] FORM_SDATA8  = 4'hc;

    // Configuration register indexes
    localparam logic [1:0] CFG_EH_ADDR   = 2'd0;
    localparam logic [1:0] CFG_TEXT_ADDR = 2'd1;
    localparam logic [1:0] CFG_DATA_ADDR = 2'd2;

    // LEB128 limit on bytes
    localparam logic [3:0] LEB_MAX_BYTES = 4'd9;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_BASE = 2'd1,
        ST_BAD_FORM = 2'd2,
        ST_LEB_LONG = 2'd3
    } t_status;

    typedef struct packed {
        logic        start_req;
        logic [7:0]  encoding;
        logic [31:0] position;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [63:0] address;
        logic [3:0]  length;
        t_status     status;
    } t_out_word;

    // Byte width of a fixed form; zero for LEB128 and unsupported forms
    function automatic logic [3:0] fixed_size(input logic [3:0] form);
        logic [3:0] sz;
        unique case (form)
            FORM_ABSPTR, FORM_UDATA8, FORM_SDATA8: sz = 4'd8;
            FORM_UDATA2, FORM_SDATA2:              sz = 4'd2;
            FORM_UDATA4, FORM_SDATA4:              sz = 4'd4;
            default:                               sz = 4'd0;
        endcase
        return sz;
    endfunction

    function automatic logic form_is_leb(input logic [3:0] form);
        return (form == FORM_ULEB128) || (form == FORM_SLEB128);
    endfunction

    function automatic logic form_signed(input logic [3:0] form);
        return (form == FORM_SLEB128) || (form == FORM_SDATA2) ||
               (form == FORM_SDATA4) || (form == FORM_SDATA8);
    endfunction

endpackage

// File: rtl/core/eh_pointer_decoder.sv
// Exception-frame encoded pointer decoder: top level, single module.
// Depends on ehpd_pkg for word types, encoding codes and status codes.
//
// A word is held in the input register, then its result in the result register.
// Throughput: one word per cycle while the result side is not stalled; a stalled
//   result holds the input register and the decoder state, and lowers o_in_ready.
// Reset (synchronous, active low) clears the busy flag, both valid flags and the
//   three section address registers; no clearing pass is needed.
module eh_pointer_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    // byte stream in
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ehpd_pkg::t_in_word  i_in,
    // decoded pointers out
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ehpd_pkg::t_out_word o_out
);
    import ehpd_pkg::*;

    // Section address registers
    logic [63:0] r_eh_addr;
    logic [63:0] r_text_addr;
    logic [63:0] r_data_addr;

    // Input register: the base is resolved on capture, so the decode stage
    // carries only one 64-bit add.
    logic        r_in_valid;
    logic        r_in_start;
    logic [3:0]  r_in_form;
    logic [63:0] r_in_base;
    logic        r_in_base_bad;
    logic [7:0]  r_in_byte;

    // Decoder state
    logic        r_busy,  n_busy;
    logic [3:0]  r_form,  n_form;
    logic [63:0] r_base,  n_base;
    logic [63:0] r_acc,   n_acc;
    logic [3:0]  r_cnt,   n_cnt;

    // Result register
    logic        r_out_valid;
    t_out_word   r_out;

    logic        in_acc;
    logic        adv;
    logic        emit;
    t_out_word   res;
    logic [63:0] cap_base;
    logic        cap_bad;

    // Advance the input register whenever the result register can take a word
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Resolve base on capture; user must change registers only while idle, unchecked
    always_comb begin
        cap_base = '0;
        cap_bad  = 1'b0;
        unique case (i_in.encoding[7:4])
            BASE_ABS:                             cap_base = '0;
            BASE_PCREL, BASE_INDIRECT, BASE_IND_PC:
                cap_base = r_eh_addr + {32'd0, i_in.position};
            BASE_TEXTREL:                         cap_base = r_text_addr;
            BASE_DATAREL:                         cap_base = r_data_addr;
            default:                              cap_bad  = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eh_addr   <= '0;
            r_text_addr <= '0;
            r_data_addr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EH_ADDR:   r_eh_addr   <= i_cfg_data;
                CFG_TEXT_ADDR: r_text_addr <= i_cfg_data;
                CFG_DATA_ADDR: r_data_addr <= i_cfg_data;
                default:       ; // drop writes past the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_start    <= i_in.start_req;
            r_in_form     <= i_in.encoding[3:0];
            r_in_base     <= cap_base;
            r_in_base_bad <= cap_bad;
            r_in_byte     <= i_in.data_byte;
        end
    end

    // Decode: fold a byte into the accumulator, finish at value end or on an error
    always_comb begin
        logic        active;
        logic [3:0]  form;
        logic [63:0] base;
        logic [63:0] acc;
        logic [3:0]  k;
        logic [3:0]  cnt1;
        logic [3:0]  size;
        logic [6:0]  sh_leb;
        logic [6:0]  sh_ext;
        logic [63:0] acc1;

        n_busy = r_busy;
        n_form = r_form;
        n_base = r_base;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        emit   = 1'b0;
        res    = '{address: '0, length: '0, status: ST_OK};

        active = 1'b0;
        form   = r_form;
        base   = r_base;
        acc    = r_acc;
        k      = r_cnt;
        cnt1   = '0;
        size   = '0;
        sh_leb = '0;
        sh_ext = '0;
        acc1   = '0;

        if (adv) begin
            if (r_in_start) begin
                // a start drops any value still being collected
                n_busy = 1'b0;
                if (r_in_base_bad) begin
                    emit       = 1'b1;
                    res.status = ST_BAD_BASE;
                end else if (!form_is_leb(r_in_form) && fixed_size(r_in_form) == 4'd0) begin
                    emit       = 1'b1;
                    res.status = ST_BAD_FORM;
                end else begin
                    active = 1'b1;
                    form   = r_in_form;
                    base   = r_in_base;
                    acc    = '0;
                    k      = '0;
                end
            end else begin
                active = r_busy;
            end
        end

        if (active) begin
            cnt1   = k + 4'd1;
            n_form = form;
            n_base = base;
            n_cnt  = cnt1;
            n_busy = 1'b1;
            if (form_is_leb(form)) begin
                sh_leb = {3'd0, k} * 7'd7;
                acc1   = acc | ({57'd0, r_in_byte[6:0]} << sh_leb);
                if (r_in_byte[7]) begin
                    if (cnt1 >= LEB_MAX_BYTES) begin
                        emit       = 1'b1;
                        res.status = ST_LEB_LONG;
                        n_busy     = 1'b0;
                    end
                end else begin
                    if (form_signed(form) && r_in_byte[6]) begin
                        sh_ext = {3'd0, cnt1} * 7'd7;
                        acc1   = acc1 | ({64{1'b1}} << sh_ext);
                    end
                    emit        = 1'b1;
                    res.address = base + acc1;
                    res.length  = cnt1;
                    n_busy      = 1'b0;
                end
                n_acc = acc1;
            end else begin
                size = fixed_size(form);
                acc1 = acc | ({56'd0, r_in_byte} << {k[2:0], 3'b000});
                if (size == 4'd0 || k >= 4'd8) begin
                    emit       = 1'b1;
                    res.status = ST_BAD_FORM;
                    n_busy     = 1'b0;
                end else if (cnt1 >= size) begin
                    if (form_signed(form)) begin
                        if (size == 4'd2 && acc1[15]) begin
                            acc1[63:16] = '1;
                        end else if (size == 4'd4 && acc1[31]) begin
                            acc1[63:32] = '1;
                        end
                    end
                    emit        = 1'b1;
                    res.address = base + acc1;
                    res.length  = size;
                    n_busy      = 1'b0;
                end
                n_acc = acc1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_form <= n_form;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
    end

    // Result register: load on a finished word, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // An error word carries neither address nor length
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> (o_out.address == '0 && o_out.length == '0))
        else $error("error word with non-zero address or length");

    // A good word consumed between one and nine bytes
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_OK) |-> (o_out.length != '0 && o_out.length <= 4'd9))
        else $error("good word with length out of range");

    // While collecting, the byte count never reaches the LEB128 limit
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < LEB_MAX_BYTES))
        else $error("byte count past limit while busy");

    // A result only leaves the decode stage when the input register advanced
    a_load_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(adv))
        else $error("result appeared without an advancing word");

endmodule

// File: bench/eh_pointer_decoder_tb.sv
// Self-checking bench for the exception-frame encoded pointer decoder.
// Depends on ehpd_pkg and eh_pointer_decoder; drives directed then random words.
`timescale 1ns / 100ps

module eh_pointer_decoder_tb;
    import ehpd_pkg::*;

    // Nibbles the package leaves out: omit, and codes no base or form uses
    localparam logic [3:0] NIB_OMIT      = 4'hf;
    localparam logic [3:0] BASE_UNUSED   = 4'h4;
    localparam logic [3:0] FORM_UNUSED   = 4'hd;
    localparam int         LIMIT_CYCLES  = 200000;
    localparam int         HOLD_CYCLES   = 250;
    localparam int         PHASE_WORDS   = 285;
    localparam int         NUM_PHASES    = 6;
    localparam int         SETTLE_CYCLES = 8;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_stim_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_EH_ADDR;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_word;

    // Bench-side flags and counters for the stimulus, the receiver and the watchdog
    logic        steady = 1'b0;
    logic        squeeze = 1'b0;
    int          hold_cycles = 0;
    int          cycle_count = 0;
    int          fails = 0;
    int          live_words = 0;

    // Our own copy of the section registers and the decode state
    logic [63:0] eh_addr = '0;
    logic [63:0] text_addr = '0;
    logic [63:0] data_addr = '0;
    bit          dec_busy = 1'b0;
    logic [3:0]  dec_form = '0;
    logic [63:0] dec_base = '0;
    logic [63:0] dec_acc = '0;
    logic [3:0]  dec_count = '0;

    t_out_word   pending_ptrs[$];
    t_in_word    word_fifo[$];
    t_stim_row   directed_rows[$];

    eh_pointer_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_word)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: no progress after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Byte width of a fixed form, zero where the form has no fixed width
    function automatic int unsigned form_width(input logic [3:0] form);
        case (form)
            FORM_ABSPTR, FORM_UDATA8, FORM_SDATA8: return 8;
            FORM_UDATA2, FORM_SDATA2:              return 2;
            FORM_UDATA4, FORM_SDATA4:              return 4;
            default:                               return 0;
        endcase
    endfunction

    function automatic t_out_word make_ptr(input logic [63:0] addr, input logic [3:0] len,
                                           input t_status st);
        t_out_word r;
        r.address = addr;
        r.length  = len;
        r.status  = st;
        return r;
    endfunction

    // Fold one byte into the value being collected; close it out when complete
    task automatic absorb_byte(input logic [7:0] b, output bit got, output t_out_word r);
        int unsigned k;
        int unsigned width;
        bit          is_signed;
        k = 32'(dec_count);
        dec_count = dec_count + 4'd1;
        got = 1'b0;
        r = '0;
        is_signed = (dec_form == FORM_SLEB128) || (dec_form == FORM_SDATA2) ||
                    (dec_form == FORM_SDATA4) || (dec_form == FORM_SDATA8);
        if (dec_form == FORM_ULEB128 || dec_form == FORM_SLEB128) begin
            dec_acc = dec_acc | (64'(b[6:0]) << (7 * k));
            if (b[7]) begin
                // continuation on the ninth byte: the value cannot fit
                if (dec_count >= LEB_MAX_BYTES) begin
                    got = 1'b1;
                    r = make_ptr('0, '0, ST_LEB_LONG);
                    dec_busy = 1'b0;
                end
            end else begin
                if (is_signed && b[6] && (7 * int'(dec_count)) < 64)
                    dec_acc = dec_acc | ({64{1'b1}} << (7 * int'(dec_count)));
                got = 1'b1;
                r = make_ptr(dec_base + dec_acc, dec_count, ST_OK);
                dec_busy = 1'b0;
            end
        end else begin
            width = form_width(dec_form);
            if (width == 0 || k >= 8) begin
                got = 1'b1;
                r = make_ptr('0, '0, ST_BAD_FORM);
                dec_busy = 1'b0;
            end else begin
                dec_acc = dec_acc | (64'(b) << (8 * k));
                if (32'(dec_count) >= width) begin
                    if (is_signed && width < 8 && dec_acc[8 * width - 1])
                        dec_acc = dec_acc | ({64{1'b1}} << (8 * width));
                    got = 1'b1;
                    r = make_ptr(dec_base + dec_acc, 4'(width), ST_OK);
                    dec_busy = 1'b0;
                end
            end
        end
    endtask

    // Predict the pointer, if any, that one accepted word produces
    task automatic decode_word(input t_in_word w, output bit got, output t_out_word r);
        logic [3:0]  base_sel;
        logic [3:0]  form;
        logic [63:0] base;
        bit          base_ok;
        got = 1'b0;
        r = '0;
        if (w.start_req) begin
            base_sel = w.encoding[7:4];
            form     = w.encoding[3:0];
            base_ok  = 1'b1;
            base     = '0;
            dec_busy = 1'b0;
            case (base_sel)
                BASE_ABS:                              base = '0;
                BASE_PCREL, BASE_INDIRECT, BASE_IND_PC: base = eh_addr + {32'h0, w.position};
                BASE_TEXTREL:                          base = text_addr;
                BASE_DATAREL:                          base = data_addr;
                default:                               base_ok = 1'b0;
            endcase
            // base is checked ahead of form
            if (!base_ok) begin
                got = 1'b1;
                r = make_ptr('0, '0, ST_BAD_BASE);
            end else if (form != FORM_ULEB128 && form != FORM_SLEB128 &&
                         form_width(form) == 0) begin
                got = 1'b1;
                r = make_ptr('0, '0, ST_BAD_FORM);
            end else begin
                dec_busy  = 1'b1;
                dec_form  = form;
                dec_base  = base;
                dec_acc   = '0;
                dec_count = '0;
                absorb_byte(w.data_byte, got, r);
            end
        end else if (dec_busy) begin
            absorb_byte(w.data_byte, got, r);
        end
    endtask

    // Offer one word, with random idle cycles ahead of it, and predict on acceptance
    task automatic send_word(input t_in_word w, output bit got, output t_out_word r);
        bit live;
        while (!steady && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        live = w.start_req || dec_busy;
        decode_word(w, got, r);
        if (live)
            live_words++;
    endtask

    // Compare one delivered pointer with the oldest prediction
    task automatic check_pointer(input t_out_word seen);
        t_out_word want;
        if (pending_ptrs.size() == 0) begin
            $display("%0t: pointer with none pending: expected none, actual %h",
                     $time, seen);
            fails++;
        end else begin
            want = pending_ptrs.pop_front();
            if (seen.address !== want.address) begin
                $display("%0t: address expected %h actual %h", $time, want.address,
                         seen.address);
                fails++;
            end
            if (seen.length !== want.length) begin
                $display("%0t: length expected %0d actual %0d", $time, want.length,
                         seen.length);
                fails++;
            end
            if (seen.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         seen.status);
                fails++;
            end
        end
    endtask

    // Receiver: take results, stall at random, and once hold off for a long stretch
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            check_pointer(out_word);
        if (squeeze && hold_cycles < HOLD_CYCLES) begin
            hold_cycles <= hold_cycles + 1;
            out_ready <= 1'b0;
        end else if (steady) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 33);
        end
    end

    task automatic add_row(input bit start, input logic [3:0] base_sel,
                           input logic [3:0] form, input logic [31:0] pos,
                           input logic [7:0] b, input bit typed, input logic [63:0] addr,
                           input logic [3:0] len, input t_status st);
        t_stim_row row;
        row.w.start_req = start;
        row.w.encoding  = {base_sel, form};
        row.w.position  = pos;
        row.w.data_byte = b;
        row.typed       = typed;
        row.want        = make_ptr(addr, len, st);
        directed_rows.push_back(row);
    endtask

    // Write all three section registers; only called right after a drain
    task automatic load_sections(input logic [63:0] eh, input logic [63:0] text,
                                 input logic [63:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_EH_ADDR;
        cfg_data <= eh;
        @(posedge clk);
        eh_addr = eh;
        cfg_idx  <= CFG_TEXT_ADDR;
        cfg_data <= text;
        @(posedge clk);
        text_addr = text;
        cfg_idx  <= CFG_DATA_ADDR;
        cfg_data <= data;
        @(posedge clk);
        data_addr = data;
        cfg_we <= 1'b0;
    endtask

    // Drop valid and let every predicted pointer come out, plus the pipeline tail
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_ptrs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic t_in_word noise_word();
        t_in_word w;
        w.start_req = 1'($urandom_range(1));
        w.encoding  = 8'($urandom_range(255));
        w.position  = $urandom;
        w.data_byte = 8'($urandom_range(255));
        return w;
    endfunction

    function automatic logic [3:0] pick_base();
        case ($urandom_range(5))
            0:       return BASE_ABS;
            1:       return BASE_PCREL;
            2:       return BASE_TEXTREL;
            3:       return BASE_DATAREL;
            4:       return BASE_INDIRECT;
            default: return BASE_IND_PC;
        endcase
    endfunction

    function automatic logic [3:0] pick_form();
        case ($urandom_range(8))
            0:       return FORM_ABSPTR;
            1:       return FORM_ULEB128;
            2:       return FORM_UDATA2;
            3:       return FORM_UDATA4;
            4:       return FORM_UDATA8;
            5:       return FORM_SLEB128;
            6:       return FORM_SDATA2;
            7:       return FORM_SDATA4;
            default: return FORM_SDATA8;
        endcase
    endfunction

    // Queue one random pointer: mostly well formed, some cut short, some noise
    task automatic build_pointer();
        int unsigned pick;
        int unsigned full;
        int unsigned keep;
        bit          leb;
        bit          overlong;
        logic [3:0]  form;
        t_in_word    w;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // fully random encoding followed by up to three stray bytes
            keep = $urandom_range(1, 4);
            for (int i = 0; i < keep; i++) begin
                w = noise_word();
                w.start_req = (i == 0);
                word_fifo.push_back(w);
            end
        end else if (pick < 12) begin
            w = noise_word();
            w.start_req = 1'b0;
            word_fifo.push_back(w);
        end else begin
            form     = pick_form();
            leb      = (form == FORM_ULEB128) || (form == FORM_SLEB128);
            overlong = 1'b0;
            if (leb) begin
                pick = $urandom_range(99);
                overlong = (pick < 6);
                if (pick < 16)
                    full = 9;
                else if (pick < 30)
                    full = $urandom_range(5, 8);
                else
                    full = $urandom_range(1, 4);
            end else begin
                full = form_width(form);
            end
            keep = full;
            // break the odd sequence off early so a new start lands mid-value
            if (full > 1 && $urandom_range(99) < 5)
                keep = $urandom_range(1, full - 1);
            for (int i = 0; i < keep; i++) begin
                w = noise_word();
                w.start_req = (i == 0);
                if (i == 0) begin
                    w.encoding = {pick_base(), form};
                    case ($urandom_range(9))
                        0:       w.position = '0;
                        1:       w.position = '1;
                        default: w.position = $urandom;
                    endcase
                end
                if (leb)
                    w.data_byte[7] = overlong || (i < full - 1);
                word_fifo.push_back(w);
            end
        end
    endtask

    initial begin
        bit        got;
        t_out_word r;
        t_in_word  w;

        // Directed words, run with every section register still at its reset value
        add_row(1'b1, NIB_OMIT, NIB_OMIT, 32'h0, 8'h00, 1'b1, '0, '0, ST_BAD_BASE);
        add_row(1'b0, BASE_ABS, FORM_ABSPTR, 32'hffff_ffff, 8'ha5, 1'b0, '0, '0, ST_OK);
        add_row(1'b1, BASE_UNUSED, FORM_UDATA2, 32'hffff_ffff, 8'hff, 1'b1, '0, '0,
                ST_BAD_BASE);
        add_row(1'b1, BASE_ABS, NIB_OMIT, 32'h0, 8'h00, 1'b1, '0, '0, ST_BAD_FORM);
        add_row(1'b1, BASE_DATAREL, FORM_UNUSED, 32'h0, 8'h00, 1'b1, '0, '0, ST_BAD_FORM);
        add_row(1'b1, BASE_ABS, FORM_ULEB128, 32'h0, 8'h7f, 1'b1, 64'h7f, 4'd1, ST_OK);
        add_row(1'b1, BASE_ABS, FORM_SLEB128, 32'h0, 8'h40, 1'b1, 64'hffff_ffff_ffff_ffc0,
                4'd1, ST_OK);
        add_row(1'b1, BASE_PCREL, FORM_SDATA2, 32'hffff_ffff, 8'h00, 1'b0, '0, '0, ST_OK);
        add_row(1'b0, BASE_ABS, FORM_ABSPTR, 32'h0, 8'h80, 1'b0, '0, '0, ST_OK);
        // start arriving while a value is still being collected
        add_row(1'b1, BASE_ABS, FORM_UDATA4, 32'h0, 8'h55, 1'b0, '0, '0, ST_OK);
        add_row(1'b1, BASE_ABS, FORM_UDATA2, 32'h0, 8'h34, 1'b0, '0, '0, ST_OK);
        add_row(1'b0, BASE_ABS, FORM_ABSPTR, 32'h0, 8'h12, 1'b1, 64'h1234, 4'd2, ST_OK);
        // continuation still set on the ninth byte
        add_row(1'b1, BASE_ABS, FORM_ULEB128, 32'h0, 8'h80, 1'b0, '0, '0, ST_OK);
        for (int i = 0; i < 7; i++)
            add_row(1'b0, BASE_ABS, FORM_ABSPTR, 32'h0, 8'h80, 1'b0, '0, '0, ST_OK);
        add_row(1'b0, BASE_ABS, FORM_ABSPTR, 32'h0, 8'h80, 1'b1, '0, '0, ST_LEB_LONG);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].w, got, r);
            if (directed_rows[i].typed)
                pending_ptrs.push_back(directed_rows[i].want);
            else if (got)
                pending_ptrs.push_back(r);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0:       load_sections('0, '0, '0);
                1:       load_sections('1, '1, '1);
                2:       load_sections(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                                       64'h1);
                default: load_sections({$urandom, $urandom}, {$urandom, $urandom},
                                       {$urandom, $urandom});
            endcase
            // one phase runs flat out on both sides
            if (phase == 4)
                steady <= 1'b1;
            live_words = 0;
            while (live_words < PHASE_WORDS) begin
                build_pointer();
                while (word_fifo.size() != 0) begin
                    w = word_fifo.pop_front();
                    send_word(w, got, r);
                    if (got)
                        pending_ptrs.push_back(r);
                end
                // hold the receiver off mid-phase while words keep coming
                if (phase == 2 && live_words >= 100)
                    squeeze <= 1'b1;
            end
            if (phase == 4)
                steady <= 1'b0;
        end

        drain();
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
